>>> rtl/tcpq_pkg.sv
// Shared types, codes and sizing constants for the three-class priority queue.
`default_nettype none

package tcpq_pkg;

	// Sizing
	localparam int CLASS_DEPTH = 16;
	localparam int NUM_CLASSES = 3;
	localparam int FIELD_W     = 27;
	localparam int PTR_W       = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
	localparam int CNT_W       = $clog2(CLASS_DEPTH + 1);
	localparam int STORE_DEPTH = NUM_CLASSES * CLASS_DEPTH;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int TOT_W       = $clog2(STORE_DEPTH + 1);
	localparam int WORD_W      = 2 * FIELD_W;
	localparam int CFG_IDX_W   = 2;

	// Register reset values
	localparam logic [FIELD_W-1:0] CUR_DATE_RST = FIELD_W'(20250502);
	localparam logic [FIELD_W-1:0] SENIOR_RST   = FIELD_W'(800000);
	localparam logic [FIELD_W-1:0] JUNIOR_RST   = FIELD_W'(100000);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CUR_DATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SENIOR   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_JUNIOR   = 2'd2;

	// Request codes
	localparam logic [1:0] REQ_INSERT   = 2'd0;
	localparam logic [1:0] REQ_POP_HEAD = 2'd1;
	localparam logic [1:0] REQ_POP_TAIL = 2'd2;
	localparam logic [1:0] REQ_CLEAR    = 2'd3;

	// Status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// Class codes
	localparam logic [1:0] CLS_SENIOR = 2'd0;
	localparam logic [1:0] CLS_JUNIOR = 2'd1;
	localparam logic [1:0] CLS_OTHER  = 2'd2;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP
	} ctl_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;   // capture the request fields
		logic exec;   // classify, update pointers, access the store
	} tcpq_cmd_t;

endpackage

`default_nettype wire

>>> rtl/tcpq_ctrl.sv
// Sequencing controller: accept, execute, respond.
`default_nettype none

module tcpq_ctrl (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic start,
	output tcpq_pkg::tcpq_cmd_t      cmd,
	output logic                     busy,
	output logic                     done
);

	tcpq_pkg::ctl_state_t state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcpq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		busy      = 1'b1;
		done      = 1'b0;
		case (state_q)
			tcpq_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = tcpq_pkg::ST_EXEC;
				end
			end
			tcpq_pkg::ST_EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = tcpq_pkg::ST_RESP;
			end
			tcpq_pkg::ST_RESP: begin
				done      = 1'b1;
				state_nxt = tcpq_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = tcpq_pkg::ST_IDLE;
			end
		endcase
	end

	// Result strobe lasts one cycle and is always followed by idle
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("result strobe not followed by idle");

	// Execute is always followed by the response cycle
	a_exec_resp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> done)
		else $error("execute not followed by response");

	// A captured transaction is executed in the next cycle
	a_load_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.exec)
		else $error("capture not followed by execute");

endmodule

`default_nettype wire

>>> rtl/tcpq_datapath.sv
// Datapath: configuration registers, class pointers, entry store and result registers.
`default_nettype none

module tcpq_datapath (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire tcpq_pkg::tcpq_cmd_t                  cmd,
	input  wire logic                                 cfg_we,
	input  wire logic [tcpq_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  wire logic [tcpq_pkg::FIELD_W-1:0]         cfg_wdata,
	input  wire logic [1:0]                           req_type,
	input  wire logic [tcpq_pkg::FIELD_W-1:0]         entry_date,
	input  wire logic [tcpq_pkg::FIELD_W-1:0]         entry_code,
	output logic [1:0]                                status,
	output logic [tcpq_pkg::FIELD_W-1:0]              out_date,
	output logic [tcpq_pkg::FIELD_W-1:0]              out_code,
	output logic [1:0]                                out_class,
	output logic [5:0]                                entry_count,
	output logic                                      queue_empty
);

	localparam int FW = tcpq_pkg::FIELD_W;
	localparam int PW = tcpq_pkg::PTR_W;
	localparam int CW = tcpq_pkg::CNT_W;
	localparam int AW = tcpq_pkg::ADDR_W;
	localparam int TW = tcpq_pkg::TOT_W;
	localparam int NC = tcpq_pkg::NUM_CLASSES;

	// Configuration registers
	logic [FW-1:0] cur_date_q, senior_q, junior_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_date_q <= tcpq_pkg::CUR_DATE_RST;
			senior_q   <= tcpq_pkg::SENIOR_RST;
			junior_q   <= tcpq_pkg::JUNIOR_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				tcpq_pkg::CFG_CUR_DATE: cur_date_q <= cfg_wdata;
				tcpq_pkg::CFG_SENIOR:   senior_q   <= cfg_wdata;
				tcpq_pkg::CFG_JUNIOR:   junior_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Captured request
	logic [1:0]    req_q;
	logic [FW-1:0] date_q, code_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_type;
			date_q <= entry_date;
			code_q <= entry_code;
		end
	end

	// Per-class FIFO pointers and counts
	logic [PW-1:0] head_q [NC];
	logic [PW-1:0] tail_q [NC];
	logic [CW-1:0] count_q [NC];

	// Age classification (signed difference, 28 bits)
	logic signed [FW:0] age, senior_s, junior_s;
	logic               senior_hit, junior_hit;
	logic [1:0]         ins_cls;

	always_comb begin
		age        = $signed({1'b0, cur_date_q}) - $signed({1'b0, date_q});
		senior_s   = $signed({1'b0, senior_q});
		junior_s   = $signed({1'b0, junior_q});
		senior_hit = age > senior_s;
		junior_hit = age < junior_s;
		if (senior_hit) begin
			ins_cls = tcpq_pkg::CLS_SENIOR;
		end else if (junior_hit) begin
			ins_cls = tcpq_pkg::CLS_JUNIOR;
		end else begin
			ins_cls = tcpq_pkg::CLS_OTHER;
		end
	end

	// Class selection for inserts and pops
	logic       ne0, ne1, ne2, found;
	logic [1:0] head_cls, tail_cls, cls_sel;

	always_comb begin
		ne0   = count_q[0] != '0;
		ne1   = count_q[1] != '0;
		ne2   = count_q[2] != '0;
		found = ne0 | ne1 | ne2;
		head_cls = ne0 ? tcpq_pkg::CLS_SENIOR :
		           ne1 ? tcpq_pkg::CLS_JUNIOR : tcpq_pkg::CLS_OTHER;
		tail_cls = ne2 ? tcpq_pkg::CLS_OTHER :
		           ne1 ? tcpq_pkg::CLS_JUNIOR : tcpq_pkg::CLS_SENIOR;
		case (req_q)
			tcpq_pkg::REQ_INSERT:   cls_sel = ins_cls;
			tcpq_pkg::REQ_POP_HEAD: cls_sel = head_cls;
			default:                cls_sel = tail_cls;
		endcase
	end

	// Slot and store address
	logic [PW-1:0] sel_head, sel_tail, head_nxt, tail_nxt, tail_prev, slot;
	logic [CW-1:0] sel_count;
	logic          is_insert, is_pop, is_clear, full, do_write, do_read;
	logic [AW-1:0] addr;

	always_comb begin
		sel_head  = head_q[cls_sel];
		sel_tail  = tail_q[cls_sel];
		sel_count = count_q[cls_sel];
		head_nxt  = (sel_head == PW'(tcpq_pkg::CLASS_DEPTH - 1)) ? '0 : sel_head + PW'(1);
		tail_nxt  = (sel_tail == PW'(tcpq_pkg::CLASS_DEPTH - 1)) ? '0 : sel_tail + PW'(1);
		tail_prev = (sel_tail == '0) ? PW'(tcpq_pkg::CLASS_DEPTH - 1) : sel_tail - PW'(1);
		is_insert = req_q == tcpq_pkg::REQ_INSERT;
		is_clear  = req_q == tcpq_pkg::REQ_CLEAR;
		is_pop    = !is_insert && !is_clear;
		full      = sel_count == CW'(tcpq_pkg::CLASS_DEPTH);
		do_write  = cmd.exec && is_insert && !full;
		do_read   = cmd.exec && is_pop && found;
		case (req_q)
			tcpq_pkg::REQ_INSERT:   slot = sel_tail;
			tcpq_pkg::REQ_POP_HEAD: slot = sel_head;
			default:                slot = tail_prev;
		endcase
		addr = AW'(cls_sel) * AW'(tcpq_pkg::CLASS_DEPTH) + AW'(slot);
	end

	// Pointer and count update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NC; c++) begin
				head_q[c]  <= '0;
				tail_q[c]  <= '0;
				count_q[c] <= '0;
			end
		end else if (cmd.exec) begin
			for (int c = 0; c < NC; c++) begin
				if (is_clear) begin
					head_q[c]  <= '0;
					tail_q[c]  <= '0;
					count_q[c] <= '0;
				end else if (cls_sel == 2'(c)) begin
					if (do_write) begin
						tail_q[c]  <= tail_nxt;
						count_q[c] <= count_q[c] + CW'(1);
					end else if (do_read) begin
						if (req_q == tcpq_pkg::REQ_POP_HEAD) begin
							head_q[c] <= head_nxt;
						end else begin
							tail_q[c] <= tail_prev;
						end
						count_q[c] <= count_q[c] - CW'(1);
					end
				end
			end
		end
	end

	// Entry store: {date, code}, registered read
	logic [tcpq_pkg::WORD_W-1:0] store [tcpq_pkg::STORE_DEPTH];
	logic [tcpq_pkg::WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (do_write) begin
			store[addr] <= {date_q, code_q};
		end
		if (do_read) begin
			rdata_q <= store[addr];
		end
	end

	// Result registers
	logic [1:0]    res_status_q, res_class_q;
	logic [FW-1:0] res_date_q, res_code_q;
	logic          use_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			use_rd_q     <= do_read;
			res_date_q   <= do_write ? date_q : '0;
			res_code_q   <= do_write ? code_q : '0;
			if (is_insert) begin
				res_status_q <= full ? tcpq_pkg::ST_FULL : tcpq_pkg::ST_DONE;
				res_class_q  <= ins_cls;
			end else if (is_pop) begin
				res_status_q <= found ? tcpq_pkg::ST_DONE : tcpq_pkg::ST_EMPTY;
				res_class_q  <= found ? cls_sel : tcpq_pkg::CLS_SENIOR;
			end else begin
				res_status_q <= tcpq_pkg::ST_DONE;
				res_class_q  <= tcpq_pkg::CLS_SENIOR;
			end
		end
	end

	// Occupancy after the step
	logic [TW-1:0] total;

	always_comb begin
		total = TW'(count_q[0]) + TW'(count_q[1]) + TW'(count_q[2]);
	end

	assign status      = res_status_q;
	assign out_class   = res_class_q;
	assign out_date    = use_rd_q ? rdata_q[tcpq_pkg::WORD_W-1:FW] : res_date_q;
	assign out_code    = use_rd_q ? rdata_q[FW-1:0] : res_code_q;
	assign entry_count = 6'(total);
	assign queue_empty = total == '0;

	// Store is never written and read in the same step
	a_no_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(do_write && do_read))
		else $error("store written and read in one step");

	// Clear leaves the queue empty
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && is_clear) |=> (total == '0))
		else $error("queue not empty after clear");

	// No class ever holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q[0] <= CW'(tcpq_pkg::CLASS_DEPTH)) &&
		(count_q[1] <= CW'(tcpq_pkg::CLASS_DEPTH)) &&
		(count_q[2] <= CW'(tcpq_pkg::CLASS_DEPTH)))
		else $error("class count above depth");

endmodule

`default_nettype wire

>>> rtl/three_class_priority_queue.sv
// Top level of the three-class strict-priority queue.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------------
//  request   | start, busy            | req_type, entry_date, entry_code
//  result    | done (1-cycle strobe)  | status, out_date, out_code, out_class,
//            |                        | entry_count, queue_empty
//  config    | cfg_we                 | cfg_addr, cfg_wdata
//
//  A transaction is accepted when start is high and busy is low. Each passes
//  through capture, execute (classify, pointer update, store access) and
//  respond; the single-port entry store and its registered read set this.
//  done is high for exactly one cycle and the receiver cannot stall it.
//  Reset clears the class pointers and counts and restores the configuration
//  registers; the entry store needs no clearing pass.
`default_nettype none

module three_class_priority_queue (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [1:0]                       req_type,
	input  wire logic [tcpq_pkg::FIELD_W-1:0]     entry_date,
	input  wire logic [tcpq_pkg::FIELD_W-1:0]     entry_code,
	output logic                                  done,
	output logic [1:0]                            status,
	output logic [tcpq_pkg::FIELD_W-1:0]          out_date,
	output logic [tcpq_pkg::FIELD_W-1:0]          out_code,
	output logic [1:0]                            out_class,
	output logic [5:0]                            entry_count,
	output logic                                  queue_empty,
	input  wire logic                             cfg_we,
	input  wire logic [tcpq_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  wire logic [tcpq_pkg::FIELD_W-1:0]     cfg_wdata
);

	tcpq_pkg::tcpq_cmd_t cmd;

	// Sequencer
	tcpq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Datapath
	tcpq_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.req_type    (req_type),
		.entry_date  (entry_date),
		.entry_code  (entry_code),
		.status      (status),
		.out_date    (out_date),
		.out_code    (out_code),
		.out_class   (out_class),
		.entry_count (entry_count),
		.queue_empty (queue_empty)
	);

endmodule

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the three-class strict-priority queue.
`timescale 1ns / 100ps

module tb;

	localparam int DATE_MAX     = 99991231;
	localparam int CODE_MAX     = 99999999;
	localparam int LIMIT_CYCLES = 300000;
	localparam int PRINT_CAP    = 40;
	localparam int FW           = tcpq_pkg::FIELD_W;
	localparam int NC           = tcpq_pkg::NUM_CLASSES;
	localparam int DEPTH        = tcpq_pkg::CLASS_DEPTH;

	// One expected result transaction
	typedef struct packed {
		logic [1:0]    status;
		logic [FW-1:0] date;
		logic [FW-1:0] code;
		logic [1:0]    cls;
		logic [5:0]    count;
		logic          empty;
	} qresult_t;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          start;
	logic          busy;
	logic [1:0]    req_type;
	logic [FW-1:0] entry_date;
	logic [FW-1:0] entry_code;
	logic          done;
	logic [1:0]    status;
	logic [FW-1:0] out_date;
	logic [FW-1:0] out_code;
	logic [1:0]    out_class;
	logic [5:0]    entry_count;
	logic          queue_empty;
	logic          cfg_we;
	logic [tcpq_pkg::CFG_IDX_W-1:0] cfg_addr;
	logic [FW-1:0] cfg_wdata;

	three_class_priority_queue uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .entry_date(entry_date), .entry_code(entry_code),
		.done(done), .status(status), .out_date(out_date), .out_code(out_code),
		.out_class(out_class), .entry_count(entry_count), .queue_empty(queue_empty),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// Queue model state and its register copy
	logic [FW-1:0] reg_cur_date, reg_senior, reg_junior;
	logic [FW-1:0] slot_date [NC][DEPTH];
	logic [FW-1:0] slot_code [NC][DEPTH];
	int            head_ptr  [NC];
	int            tail_ptr  [NC];
	int            cls_count [NC];

	qresult_t awaited_q[$];

	int n_errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_cycles = 0;
	int gap_pct = 0;
	int n_stored = 0, n_refused = 0, n_pops = 0, n_empty_pops = 0, n_clears = 0;
	int n_settings = 1;

	// Model of one request: classify, update the class FIFOs, form the result
	function automatic qresult_t apply_request(logic [1:0] req, logic [FW-1:0] date,
			logic [FW-1:0] code);
		qresult_t r;
		longint   age;
		int       c, s, found, total;
		r = '0;
		r.status = tcpq_pkg::ST_DONE;
		found = -1;
		case (req)
			tcpq_pkg::REQ_INSERT: begin
				age = longint'(reg_cur_date) - longint'(date);
				if (age > longint'(reg_senior))
					c = tcpq_pkg::CLS_SENIOR;
				else if (age < longint'(reg_junior))
					c = tcpq_pkg::CLS_JUNIOR;
				else
					c = tcpq_pkg::CLS_OTHER;
				r.cls = c[1:0];
				if (cls_count[c] >= DEPTH) begin
					r.status = tcpq_pkg::ST_FULL;
					n_refused++;
				end else begin
					slot_date[c][tail_ptr[c]] = date;
					slot_code[c][tail_ptr[c]] = code;
					tail_ptr[c] = (tail_ptr[c] + 1) % DEPTH;
					cls_count[c]++;
					r.date = date;
					r.code = code;
					n_stored++;
				end
			end
			tcpq_pkg::REQ_POP_HEAD, tcpq_pkg::REQ_POP_TAIL: begin
				// head pops favor class 0, tail pops favor class 2
				if (req == tcpq_pkg::REQ_POP_HEAD) begin
					for (c = 0; c < NC; c++)
						if (found < 0 && cls_count[c] != 0) found = c;
				end else begin
					for (c = NC - 1; c >= 0; c--)
						if (found < 0 && cls_count[c] != 0) found = c;
				end
				if (found < 0) begin
					r.status = tcpq_pkg::ST_EMPTY;
					n_empty_pops++;
				end else begin
					if (req == tcpq_pkg::REQ_POP_HEAD) begin
						s = head_ptr[found];
						head_ptr[found] = (s + 1) % DEPTH;
					end else begin
						s = (tail_ptr[found] + DEPTH - 1) % DEPTH;
						tail_ptr[found] = s;
					end
					cls_count[found]--;
					r.date = slot_date[found][s];
					r.code = slot_code[found][s];
					r.cls = found[1:0];
					n_pops++;
				end
			end
			default: begin
				for (c = 0; c < NC; c++) begin
					head_ptr[c] = 0;
					tail_ptr[c] = 0;
					cls_count[c] = 0;
				end
				n_clears++;
			end
		endcase
		total = 0;
		for (c = 0; c < NC; c++)
			total += cls_count[c];
		r.count = total[5:0];
		r.empty = (total == 0);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		n_errors++;
		// keep the log short when something is badly broken
		if (n_errors <= PRINT_CAP)
			$display("MISMATCH result %0d: %s got %0d expected %0d",
				n_checked, what, got, want);
	endtask

	// Result checker: every strobe is matched with the oldest expectation
	always @(posedge clk) begin
		qresult_t want;
		if (arst_n && done) begin
			if (awaited_q.size() == 0) begin
				report_mismatch("result with nothing awaited, status", status, 0);
			end else begin
				want = awaited_q.pop_front();
				if (status !== want.status) report_mismatch("status", status, want.status);
				if (out_date !== want.date) report_mismatch("out_date", out_date, want.date);
				if (out_code !== want.code) report_mismatch("out_code", out_code, want.code);
				if (out_class !== want.cls) report_mismatch("out_class", out_class, want.cls);
				if (entry_count !== want.count)
					report_mismatch("entry_count", entry_count, want.count);
				if (queue_empty !== want.empty)
					report_mismatch("queue_empty", queue_empty, want.empty);
			end
			n_checked++;
		end
	end

	// Cycle limit
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles == LIMIT_CYCLES) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				n_cycles, awaited_q.size());
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [FW-1:0] random_date();
		return FW'($urandom_range(DATE_MAX, 0));
	endfunction

	function automatic logic [FW-1:0] random_code();
		return FW'($urandom_range(CODE_MAX, 0));
	endfunction

	// Date that lands in the given class under the current registers,
	// often right on a threshold boundary; random if the class is unreachable
	function automatic logic [FW-1:0] date_for_class(int cls);
		longint lo, hi;
		case (cls)
			tcpq_pkg::CLS_SENIOR: begin
				lo = 0;
				hi = longint'(reg_cur_date) - longint'(reg_senior) - 1;
			end
			tcpq_pkg::CLS_JUNIOR: begin
				lo = longint'(reg_cur_date) - longint'(reg_junior) + 1;
				hi = DATE_MAX;
			end
			default: begin
				lo = longint'(reg_cur_date) - longint'(reg_senior);
				hi = longint'(reg_cur_date) - longint'(reg_junior);
			end
		endcase
		if (lo < 0) lo = 0;
		if (hi > DATE_MAX) hi = DATE_MAX;
		if (lo > hi) return random_date();
		case ($urandom_range(3))
			0: return FW'(lo);
			1: return FW'(hi);
			default: return FW'($urandom_range(int'(hi), int'(lo)));
		endcase
	endfunction

	task automatic idle_cycle();
		@(negedge clk);
		start <= 1'b0;
		req_type <= 2'($urandom_range(3));
		entry_date <= random_date();
		entry_code <= random_code();
	endtask

	// Send one request transaction and record its expected result
	task automatic send_req(logic [1:0] req, logic [FW-1:0] date,
			logic [FW-1:0] code);
		while ($urandom_range(99) < gap_pct)
			idle_cycle();
		@(negedge clk);
		start <= 1'b1;
		req_type <= req;
		entry_date <= date;
		entry_code <= code;
		do @(posedge clk); while (busy);
		awaited_q.push_back(apply_request(req, date, code));
		n_sent++;
	endtask

	task automatic send_mixed();
		int pick;
		pick = $urandom_range(99);
		if (pick < 50)
			send_req(tcpq_pkg::REQ_INSERT,
				$urandom_range(1) ? date_for_class($urandom_range(2)) : random_date(),
				random_code());
		else if (pick < 72)
			send_req(tcpq_pkg::REQ_POP_HEAD, random_date(), random_code());
		else if (pick < 95)
			send_req(tcpq_pkg::REQ_POP_TAIL, random_date(), random_code());
		else
			send_req(tcpq_pkg::REQ_CLEAR, random_date(), random_code());
	endtask

	// Stop sending and wait until every awaited result has come
	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (awaited_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [tcpq_pkg::CFG_IDX_W-1:0] idx, logic [FW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			tcpq_pkg::CFG_CUR_DATE: reg_cur_date = val;
			tcpq_pkg::CFG_SENIOR:   reg_senior = val;
			default:                reg_junior = val;
		endcase
	endtask

	task automatic set_config(int cur, int senior, int junior);
		wait_idle();
		write_reg(tcpq_pkg::CFG_CUR_DATE, FW'(cur));
		write_reg(tcpq_pkg::CFG_SENIOR, FW'(senior));
		write_reg(tcpq_pkg::CFG_JUNIOR, FW'(junior));
		@(negedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic apply_reset();
		int c;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = tcpq_pkg::REQ_INSERT;
		entry_date = '0;
		entry_code = '0;
		cfg_we = 1'b0;
		cfg_addr = tcpq_pkg::CFG_CUR_DATE;
		cfg_wdata = '0;
		reg_cur_date = tcpq_pkg::CUR_DATE_RST;
		reg_senior = tcpq_pkg::SENIOR_RST;
		reg_junior = tcpq_pkg::JUNIOR_RST;
		for (c = 0; c < NC; c++) begin
			head_ptr[c] = 0;
			tail_ptr[c] = 0;
			cls_count[c] = 0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	endtask

	// Empty pops, class boundaries, field extremes, every request, clear
	task automatic test_directed_requests();
		gap_pct = 0;
		send_req(tcpq_pkg::REQ_POP_HEAD, '0, '0);
		send_req(tcpq_pkg::REQ_POP_TAIL, FW'(DATE_MAX), FW'(CODE_MAX));
		send_req(tcpq_pkg::REQ_INSERT, '0, '0);
		send_req(tcpq_pkg::REQ_INSERT, FW'(DATE_MAX), FW'(CODE_MAX));
		send_req(tcpq_pkg::REQ_INSERT, reg_cur_date - reg_senior, random_code());
		send_req(tcpq_pkg::REQ_INSERT, reg_cur_date - reg_senior - 1, random_code());
		send_req(tcpq_pkg::REQ_INSERT, reg_cur_date - reg_junior, random_code());
		send_req(tcpq_pkg::REQ_INSERT, reg_cur_date - reg_junior + 1, random_code());
		send_req(tcpq_pkg::REQ_INSERT, reg_cur_date, FW'(CODE_MAX));
		send_req(tcpq_pkg::REQ_POP_HEAD, random_date(), random_code());
		send_req(tcpq_pkg::REQ_POP_TAIL, random_date(), random_code());
		send_req(tcpq_pkg::REQ_POP_HEAD, random_date(), random_code());
		send_req(tcpq_pkg::REQ_POP_TAIL, random_date(), random_code());
		send_req(tcpq_pkg::REQ_POP_TAIL, random_date(), random_code());
		send_req(tcpq_pkg::REQ_POP_HEAD, random_date(), random_code());
		send_req(tcpq_pkg::REQ_INSERT, random_date(), random_code());
		send_req(tcpq_pkg::REQ_CLEAR, random_date(), random_code());
		send_req(tcpq_pkg::REQ_POP_HEAD, random_date(), random_code());
		send_req(tcpq_pkg::REQ_CLEAR, '0, '0);
		wait_idle();
	endtask

	// Register extremes: each setting gets a short run of mixed traffic
	task automatic test_config_extremes();
		int cur_v [5] = '{0, DATE_MAX, DATE_MAX, 0, DATE_MAX};
		int sen_v [5] = '{0, DATE_MAX, 0, DATE_MAX, 0};
		int jun_v [5] = '{0, 0, DATE_MAX, DATE_MAX, 0};
		int i;
		gap_pct = 14;
		for (i = 0; i < 5; i++) begin
			set_config(cur_v[i], sen_v[i], jun_v[i]);
			repeat (40) send_mixed();
		end
	endtask

	// Bursts of fills, drains and mixed requests under random registers
	task automatic test_random_traffic(int idle_pct, int n_items);
		int goal, next_cfg, mode, k, cls, senior;
		gap_pct = idle_pct;
		goal = n_sent + n_items;
		next_cfg = n_sent;
		while (n_sent < goal) begin
			if (n_sent >= next_cfg) begin
				senior = $urandom_range(1200000, 0);
				set_config($urandom_range(20991231, 19000101), senior,
					$urandom_range(700000, 0));
				next_cfg = n_sent + 150;
			end
			mode = $urandom_range(99);
			k = $urandom_range(20, 4);
			if (mode < 40) begin
				cls = $urandom_range(2);
				repeat (k) send_req(tcpq_pkg::REQ_INSERT, date_for_class(cls), random_code());
			end else if (mode < 70) begin
				repeat (k) send_req($urandom_range(1) ? tcpq_pkg::REQ_POP_HEAD
					: tcpq_pkg::REQ_POP_TAIL, random_date(), random_code());
			end else if (mode < 96) begin
				repeat (k) send_mixed();
			end else if (mode < 98) begin
				send_req(tcpq_pkg::REQ_CLEAR, random_date(), random_code());
			end else begin
				wait_idle();
			end
		end
	endtask

	initial begin
		apply_reset();
		test_directed_requests();
		test_config_extremes();
		test_random_traffic(14, 550);
		test_random_traffic(63, 550);
		test_random_traffic(0, 550);
		wait_idle();
		repeat (8) @(posedge clk);
		$display("Ran %0d transactions over %0d register settings:",
			n_sent, n_settings);
		$display("%0d inserts stored, %0d refused, %0d pops returned an entry,",
			n_stored, n_refused, n_pops);
		$display("%0d pops found the queue empty, %0d clears", n_empty_pops, n_clears);
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
